/* src/cdadd_pkg.sv */
// Shared types, constants and calendar helpers for the date adder.
// Used by the microcode ROM, the datapath and the top level.
// No dependencies.
package cdadd_pkg;

    // Field widths
    localparam int YEAR_W     = 14;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int DELTA_W    = 15;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    // Working widths
    localparam int WORD_W = 16;   // signed year, signed day, accumulator
    localparam int RES_W  = 9;    // year modulo 400
    localparam int PC_W   = 4;
    localparam int K_W    = 4;

    // Calendar limits
    localparam int YEAR_MIN    = 1;
    localparam int YEAR_MAX    = 9999;
    localparam int DELTA_LIMIT = 9999;

    // Year modulo 400: bias by 32 times 400 years so the value is positive,
    // then peel off 400 << k for k = 5 down to 0.
    localparam int CYCLE_YEARS = 400;
    localparam int YMOD_TOP_K  = 5;
    localparam int YMOD_BIAS   = CYCLE_YEARS << YMOD_TOP_K;

    // Month count split: bias by 1024 years, then peel off 12 << k for
    // k = 10 down to 0.
    localparam int YEAR_MONTHS = 12;
    localparam int MON_TOP_K   = 10;
    localparam int MON_BIAS_Y  = 1 << MON_TOP_K;
    localparam int MON_BIAS    = YEAR_MONTHS << MON_TOP_K;

    // Microcode addresses that are jump targets
    localparam logic [PC_W-1:0] PC_YMOD_LOOP  = 4'd1;
    localparam logic [PC_W-1:0] PC_DFWD       = 4'd4;
    localparam logic [PC_W-1:0] PC_DBACK      = 4'd5;
    localparam logic [PC_W-1:0] PC_MINIT      = 4'd7;
    localparam logic [PC_W-1:0] PC_MSTEP      = 4'd8;
    localparam logic [PC_W-1:0] PC_YMOD_LOOP2 = 4'd10;
    localparam logic [PC_W-1:0] PC_DONE       = 4'd13;
    localparam logic [PC_W-1:0] PC_START      = 4'd0;

    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_YMOD_INIT = 4'd1,
        OP_YMOD_STEP = 4'd2,
        OP_RSET      = 4'd3,
        OP_DADD      = 4'd4,
        OP_DFWD      = 4'd5,
        OP_DBACK     = 4'd6,
        OP_MINIT     = 4'd7,
        OP_MSTEP     = 4'd8,
        OP_MSET      = 4'd9,
        OP_CLAMP     = 4'd10,
        OP_DONE      = 4'd11
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER  = 3'd0,
        C_ALWAYS = 3'd1,
        C_KNZ    = 3'd2,
        C_FUNC   = 3'd3,
        C_DOVER  = 3'd4,
        C_DLOW   = 3'd5,
        C_OBUSY  = 3'd6
    } t_cond;

    typedef enum logic {
        FUNC_ADD_DAYS   = 1'b0,
        FUNC_ADD_MONTHS = 1'b1
    } t_func;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ctrl_word;

    typedef struct packed {
        logic k_nz;
        logic func;
        logic d_over;
        logic d_low;
    } t_dp_status;

    typedef struct packed {
        logic                      func;
        logic [YEAR_W-1:0]         year;
        logic [MONTH_W-1:0]        month;
        logic [DAY_W-1:0]          day;
        logic signed [DELTA_W-1:0] delta;
    } t_item;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               oor;
    } t_result;

    // Leap test on the year taken modulo 400
    function automatic logic is_leap(input logic [RES_W-1:0] yr_mod);
        return (yr_mod[1:0] == 2'd0) && (yr_mod != 9'd100) &&
               (yr_mod != 9'd200) && (yr_mod != 9'd300);
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        case (month) inside
            4'd2:                  len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:               len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* src/calendar_date_add_unit.sv */
// Gregorian date adder: add days or months to a date, microcoded.
// Add days walks the date month by month, F months forward and B back,
// F + B being at most about 330 for a 9999-day delta.
// A new item is taken only once the last result is in the output register.
// Reset (i_rst_n, synchronous, active low) clears sequencer and output valid.
// Depends on cdadd_pkg, cdadd_rom and cdadd_datapath.
module calendar_date_add_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: start_year[13:0], start_month[17:14], start_day[22:18],
    //        delta[37:23], zero fill[39:38]
    input  logic [cdadd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: func (0 add days, 1 add months)
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: result_year[13:0], result_month[17:14], result_day[22:18],
    //        zero fill[23]
    output logic [cdadd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // tuser: out_of_range
    output logic                              m_axis_tuser
);
    import cdadd_pkg::*;

    logic [PC_W-1:0]       r_pc, n_pc;
    logic                  r_busy, n_busy;
    logic                  r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic                  r_out_user, n_out_user;

    t_ctrl_word word;
    t_dp_status status;
    t_result    result;
    t_item      item;
    logic       in_xfer;
    logic       out_free;
    logic       take;
    logic       done_fire;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // Unpack the input transfer
    always_comb begin
        item.func  = s_axis_tuser;
        item.year  = s_axis_tdata[13:0];
        item.month = s_axis_tdata[17:14];
        item.day   = s_axis_tdata[22:18];
        item.delta = $signed(s_axis_tdata[37:23]);
    end

    cdadd_rom u_rom (
        .i_pc   (r_pc),
        .o_word (word)
    );

    cdadd_datapath u_datapath (
        .i_clk    (i_clk),
        .i_load   (in_xfer),
        .i_item   (item),
        .i_exec   (r_busy),
        .i_op     (word.op),
        .o_status (status),
        .o_result (result)
    );

    // Evaluate the jump condition of the current step
    always_comb begin
        case (word.cond)
            C_NEVER:  take = 1'b0;
            C_ALWAYS: take = 1'b1;
            C_KNZ:    take = status.k_nz;
            C_FUNC:   take = status.func;
            C_DOVER:  take = status.d_over;
            C_DLOW:   take = status.d_low;
            C_OBUSY:  take = !out_free;
            default:  take = 1'b0;
        endcase
        done_fire = r_busy && (word.op == OP_DONE) && out_free;
    end

    // Advance the step counter, load the output register
    always_comb begin
        n_pc        = r_pc;
        n_busy      = r_busy;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        if (in_xfer) begin
            n_pc   = PC_START;
            n_busy = 1'b1;
        end else if (done_fire) begin
            n_pc   = PC_START;
            n_busy = 1'b0;
        end else if (r_busy) begin
            n_pc = take ? word.target : r_pc + 4'd1;
        end
        if (done_fire) begin
            n_out_valid = 1'b1;
            n_out_data  = {1'b0, result.day, result.month, result.year};
            n_out_user  = result.oor;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_START;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign s_axis_tready = !r_busy;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

`ifndef ASSERT_OFF
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_busy && r_pc == PC_START))
        else $error("sequencer did not start on an input transfer");

    a_done_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_fire |=> (m_axis_tvalid && !r_busy))
        else $error("finished item did not reach the output register");

    a_year_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[13:0] >= 14'd1 && m_axis_tdata[13:0] <= 14'd9999))
        else $error("result year outside its limits");

    a_month_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[17:14] >= 4'd1 && m_axis_tdata[17:14] <= 4'd12))
        else $error("result month outside 1 to 12");
`endif

endmodule

/* src/cdadd_rom.sv */
// Microcode ROM of the date adder: one control word per program step.
// Depends on cdadd_pkg for the control word layout and addresses.
module cdadd_rom (
    input  logic [cdadd_pkg::PC_W-1:0] i_pc,
    output cdadd_pkg::t_ctrl_word      o_word
);
    import cdadd_pkg::*;

    // Decode program address into operation, jump condition and target
    always_comb begin
        unique case (i_pc)
            4'd0:    o_word = '{OP_YMOD_INIT, C_NEVER,  PC_START};
            4'd1:    o_word = '{OP_YMOD_STEP, C_KNZ,    PC_YMOD_LOOP};
            4'd2:    o_word = '{OP_RSET,      C_FUNC,   PC_MINIT};
            4'd3:    o_word = '{OP_DADD,      C_NEVER,  PC_START};
            4'd4:    o_word = '{OP_DFWD,      C_DOVER,  PC_DFWD};
            4'd5:    o_word = '{OP_DBACK,     C_DLOW,   PC_DBACK};
            4'd6:    o_word = '{OP_NOP,       C_ALWAYS, PC_DONE};
            4'd7:    o_word = '{OP_MINIT,     C_NEVER,  PC_START};
            4'd8:    o_word = '{OP_MSTEP,     C_KNZ,    PC_MSTEP};
            4'd9:    o_word = '{OP_MSET,      C_NEVER,  PC_START};
            4'd10:   o_word = '{OP_YMOD_STEP, C_KNZ,    PC_YMOD_LOOP2};
            4'd11:   o_word = '{OP_RSET,      C_NEVER,  PC_START};
            4'd12:   o_word = '{OP_CLAMP,     C_NEVER,  PC_START};
            4'd13:   o_word = '{OP_DONE,      C_OBUSY,  PC_DONE};
            default: o_word = '{OP_NOP,       C_ALWAYS, PC_DONE};
        endcase
    end

endmodule

/* src/cdadd_datapath.sv */
// Datapath of the date adder: year, month, day, year-mod-400, accumulator
// and step count registers driven by the microcode operation.
// Depends on cdadd_pkg.
module cdadd_datapath (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  cdadd_pkg::t_item      i_item,
    input  logic                  i_exec,
    input  cdadd_pkg::t_op        i_op,
    output cdadd_pkg::t_dp_status o_status,
    output cdadd_pkg::t_result    o_result
);
    import cdadd_pkg::*;

    logic signed [WORD_W-1:0]  r_y, n_y;
    logic signed [WORD_W-1:0]  r_d, n_d;
    logic [MONTH_W-1:0]        r_m, n_m;
    logic [RES_W-1:0]          r_r, n_r;
    logic [WORD_W-1:0]         r_a, n_a;
    logic [K_W-1:0]            r_k, n_k;
    logic                      r_func, n_func;
    logic signed [DELTA_W-1:0] r_delta, n_delta;

    logic [DAY_W-1:0]         dim_cur, dim_prev;
    logic [MONTH_W-1:0]       m_prev;
    logic [RES_W-1:0]         res_prev, res_inc;
    logic signed [WORD_W-1:0] dim_cur_s, dim_prev_s;
    logic [WORD_W-1:0]        sub_val;
    logic                     a_ge;
    logic signed [WORD_W:0]   mon_sum;
    logic [WORD_W-1:0]        y_biased;

    // Month lengths of the current and the previous month
    always_comb begin
        m_prev = (r_m == 4'd1) ? 4'd12 : r_m - 4'd1;
        if (r_m == 4'd1) begin
            res_prev = (r_r == '0) ? RES_W'(CYCLE_YEARS - 1) : r_r - 9'd1;
        end else begin
            res_prev = r_r;
        end
        res_inc    = (r_r == RES_W'(CYCLE_YEARS - 1)) ? '0 : r_r + 9'd1;
        dim_cur    = days_in(r_m, is_leap(r_r));
        dim_prev   = days_in(m_prev, is_leap(res_prev));
        dim_cur_s  = $signed({11'd0, dim_cur});
        dim_prev_s = $signed({11'd0, dim_prev});
    end

    // Shift-subtract step: compare against 12 << k or 400 << k
    always_comb begin
        if (i_op == OP_MSTEP) begin
            sub_val = WORD_W'(YEAR_MONTHS) << r_k;
        end else begin
            sub_val = WORD_W'(CYCLE_YEARS) << r_k;
        end
        a_ge     = r_a >= sub_val;
        mon_sum  = $signed({13'd0, r_m}) + (WORD_W+1)'(r_delta) - 17'sd1
                   + (WORD_W+1)'(MON_BIAS);
        y_biased = WORD_W'(r_y + WORD_W'(YMOD_BIAS));
    end

    // Next state of the working registers
    always_comb begin
        n_y     = r_y;
        n_d     = r_d;
        n_m     = r_m;
        n_r     = r_r;
        n_a     = r_a;
        n_k     = r_k;
        n_func  = r_func;
        n_delta = r_delta;
        if (i_load) begin
            // Saturate the fields of the incoming transfer
            n_func = i_item.func;
            if (i_item.year == '0) begin
                n_y = WORD_W'(YEAR_MIN);
            end else if (i_item.year > YEAR_W'(YEAR_MAX)) begin
                n_y = WORD_W'(YEAR_MAX);
            end else begin
                n_y = $signed({2'd0, i_item.year});
            end
            if (i_item.month == '0) begin
                n_m = 4'd1;
            end else if (i_item.month > 4'd12) begin
                n_m = 4'd12;
            end else begin
                n_m = i_item.month;
            end
            n_d = (i_item.day == '0) ? 16'sd1 : $signed({11'd0, i_item.day});
            if (i_item.delta > DELTA_W'(DELTA_LIMIT)) begin
                n_delta = DELTA_W'(DELTA_LIMIT);
            end else if (i_item.delta < -DELTA_W'(DELTA_LIMIT)) begin
                n_delta = -DELTA_W'(DELTA_LIMIT);
            end else begin
                n_delta = i_item.delta;
            end
        end else if (i_exec) begin
            case (i_op)
                OP_YMOD_INIT: begin
                    n_a = y_biased;
                    n_k = K_W'(YMOD_TOP_K);
                end
                OP_YMOD_STEP: begin
                    if (a_ge) begin
                        n_a = r_a - sub_val;
                    end
                    n_k = r_k - 4'd1;
                end
                OP_RSET: begin
                    n_r = r_a[RES_W-1:0];
                end
                OP_DADD: begin
                    n_d = r_d + WORD_W'(r_delta);
                end
                OP_DFWD: begin
                    // Step forward one month, carry into the year
                    if (r_d > dim_cur_s) begin
                        n_d = r_d - dim_cur_s;
                        if (r_m == 4'd12) begin
                            n_m = 4'd1;
                            n_y = r_y + 16'sd1;
                            n_r = res_inc;
                        end else begin
                            n_m = r_m + 4'd1;
                        end
                    end
                end
                OP_DBACK: begin
                    // Step back one month, borrow from the year
                    if (r_d <= 16'sd0) begin
                        n_m = m_prev;
                        n_r = res_prev;
                        n_d = r_d + dim_prev_s;
                        if (r_m == 4'd1) begin
                            n_y = r_y - 16'sd1;
                        end
                    end
                end
                OP_MINIT: begin
                    n_a = mon_sum[WORD_W-1:0];
                    n_y = r_y - WORD_W'(MON_BIAS_Y);
                    n_k = K_W'(MON_TOP_K);
                end
                OP_MSTEP: begin
                    if (a_ge) begin
                        n_a = r_a - sub_val;
                        n_y = r_y + $signed(WORD_W'(1) << r_k);
                    end
                    n_k = r_k - 4'd1;
                end
                OP_MSET: begin
                    n_m = r_a[MONTH_W-1:0] + 4'd1;
                    n_a = y_biased;
                    n_k = K_W'(YMOD_TOP_K);
                end
                OP_CLAMP: begin
                    if (r_d > dim_cur_s) begin
                        n_d = dim_cur_s;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Hold working registers
    always_ff @(posedge i_clk) begin
        r_y     <= n_y;
        r_d     <= n_d;
        r_m     <= n_m;
        r_r     <= n_r;
        r_a     <= n_a;
        r_k     <= n_k;
        r_func  <= n_func;
        r_delta <= n_delta;
    end

    // Status toward the sequencer
    always_comb begin
        o_status.k_nz   = r_k != '0;
        o_status.func   = r_func == FUNC_ADD_MONTHS;
        o_status.d_over = r_d > dim_cur_s;
        o_status.d_low  = r_d <= 16'sd0;
    end

    // Final date with the year held to its limits
    always_comb begin
        o_result.month = r_m;
        o_result.day   = r_d[DAY_W-1:0];
        if (r_y < WORD_W'(YEAR_MIN)) begin
            o_result.year = YEAR_W'(YEAR_MIN);
            o_result.oor  = 1'b1;
        end else if (r_y > WORD_W'(YEAR_MAX)) begin
            o_result.year = YEAR_W'(YEAR_MAX);
            o_result.oor  = 1'b1;
        end else begin
            o_result.year = r_y[YEAR_W-1:0];
            o_result.oor  = 1'b0;
        end
    end

endmodule
